// File: hdl/cvd_pkg.sv
`timescale 1ns / 1ps

package cvd_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned LenWidth   = 4;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_UNDERFLOW = 1'b1;

  typedef struct packed {
    logic                  produce;
    logic                  status;
    logic [ValueWidth-1:0] value;
  } cvd_result_t;

  // count leading ones of the lead word, plus one
  function automatic logic [LenWidth-1:0] length_of(input logic [7:0] lead);
    logic [LenWidth-1:0] len;
    if (lead < 8'h80)      len = 4'd1;
    else if (lead < 8'hC0) len = 4'd2;
    else if (lead < 8'hE0) len = 4'd3;
    else if (lead < 8'hF0) len = 4'd4;
    else if (lead < 8'hF8) len = 4'd5;
    else if (lead < 8'hFC) len = 4'd6;
    else if (lead < 8'hFE) len = 4'd7;
    else if (lead < 8'hFF) len = 4'd8;
    else                   len = 4'd9;
    return len;
  endfunction

  function automatic logic [ValueWidth-1:0] form_value(
    input logic [7:0]            lead,
    input logic [LenWidth-1:0]   len,
    input logic [ValueWidth-1:0] acc,
    input logic                  long_mode
  );
    logic [ValueWidth-1:0] v;
    if (!long_mode && (len >= 4'd5)) begin
      v = {{32{acc[31]}}, acc[31:0]};
    end else begin
      case (len)
        4'd1:    v = {{57{lead[6]}}, lead[6:0]};
        4'd2:    v = {{50{lead[5]}}, lead[5:0], acc[7:0]};
        4'd3:    v = {{43{lead[4]}}, lead[4:0], acc[15:0]};
        4'd4:    v = {{36{lead[3]}}, lead[3:0], acc[23:0]};
        4'd5:    v = {{29{lead[2]}}, lead[2:0], acc[31:0]};
        4'd6:    v = {{22{lead[1]}}, lead[1:0], acc[39:0]};
        4'd7:    v = {{15{lead[0]}}, lead[0], acc[47:0]};
        4'd8:    v = {{8{acc[55]}}, acc[55:0]};
        default: v = acc;
      endcase
    end
    return v;
  endfunction

endpackage

// File: hdl/cvd_decode.sv
`timescale 1ns / 1ps

module cvd_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 buffer_end,
  input  logic                 long_mode,
  output cvd_pkg::cvd_result_t res
);

  logic [cvd_pkg::LenWidth-1:0]   bytes_seen_r, bytes_seen_nxt;
  logic [cvd_pkg::LenWidth-1:0]   total_length_r, total_length_nxt;
  logic [7:0]                     lead_byte_r, lead_byte_nxt;
  logic [cvd_pkg::ValueWidth-1:0] acc_r, acc_nxt;

  logic [cvd_pkg::LenWidth-1:0]   len_lead;
  logic [cvd_pkg::LenWidth-1:0]   seen_inc;
  logic [cvd_pkg::ValueWidth-1:0] acc_shift;

  always_comb begin
    len_lead         = cvd_pkg::length_of(data_byte);
    seen_inc         = bytes_seen_r + 4'd1;
    acc_shift        = {acc_r[cvd_pkg::ValueWidth-9:0], data_byte};
    bytes_seen_nxt   = bytes_seen_r;
    total_length_nxt = total_length_r;
    lead_byte_nxt    = lead_byte_r;
    acc_nxt          = acc_r;
    res.produce      = 1'b0;
    res.status       = cvd_pkg::STATUS_OK;
    res.value        = '0;
    if (bytes_seen_r == '0) begin
      if (len_lead == 4'd1) begin
        res.produce = 1'b1;
        res.value   = cvd_pkg::form_value(data_byte, 4'd1, '0, long_mode);
      end else if (buffer_end) begin
        res.produce = 1'b1;
        res.status  = cvd_pkg::STATUS_UNDERFLOW;
      end else begin
        bytes_seen_nxt   = 4'd1;
        total_length_nxt = len_lead;
        lead_byte_nxt    = data_byte;
        acc_nxt          = '0;
      end
    end else begin
      if (seen_inc >= total_length_r) begin
        res.produce      = 1'b1;
        res.value        = cvd_pkg::form_value(lead_byte_r, total_length_r, acc_shift,
                                               long_mode);
        bytes_seen_nxt   = '0;
        total_length_nxt = '0;
      end else if (buffer_end) begin
        res.produce      = 1'b1;
        res.status       = cvd_pkg::STATUS_UNDERFLOW;
        bytes_seen_nxt   = '0;
        total_length_nxt = '0;
      end else begin
        bytes_seen_nxt = seen_inc;
        acc_nxt        = acc_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r   <= '0;
      total_length_r <= '0;
    end else if (step) begin
      bytes_seen_r   <= bytes_seen_nxt;
      total_length_r <= total_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lead_byte_r <= lead_byte_nxt;
      acc_r       <= acc_nxt;
    end
  end

  a_idle_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_seen_r == '0) |-> (total_length_r == '0))
    else $error("length held while idle");

  a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_seen_r != '0) |-> (total_length_r >= 4'd2 && bytes_seen_r < total_length_r))
    else $error("byte count past value length");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.produce && res.status == cvd_pkg::STATUS_UNDERFLOW) |-> (res.value == '0))
    else $error("underflow result carries a value");

endmodule

// File: hdl/compact_varint_decoder.sv
`timescale 1ns / 1ps
// Each word waits in the input register; any result it gives is registered for out_valid.
// Throughput: one word per cycle; in_ready drops only while a result is waiting
//   in the output register and the word in the input register would produce another.
// Reset (rst_n, synchronous, active low): input and output registers empty,
//   decoder idle, long mode on.

module compact_varint_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_buffer_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_decoded_value,
  output logic               out_status,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  logic                           long_mode_r;
  logic                           s1_valid_r;
  logic [7:0]                     s1_byte_r;
  logic                           s1_end_r;
  logic                           out_valid_r;
  logic [cvd_pkg::ValueWidth-1:0] out_value_r;
  logic                           out_status_r;
  logic                           advance;
  cvd_pkg::cvd_result_t           dec_res;

  cvd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (s1_byte_r),
    .buffer_end (s1_end_r),
    .long_mode  (long_mode_r),
    .res        (dec_res)
  );

  always_comb begin
    advance  = s1_valid_r && (!dec_res.produce || !out_valid_r || out_ready);
    in_ready = !s1_valid_r || advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      long_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && dec_res.produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_res.produce) begin
      out_value_r  <= dec_res.value;
      out_status_r <= dec_res.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decoded_value = $signed(out_value_r);
  assign out_status        = out_status_r;

  a_ready_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a waiting result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_value_r)
                                     && $stable(out_status_r)))
    else $error("waiting result overwritten");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && dec_res.produce) |=> out_valid_r)
    else $error("decoded result lost");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic       buf_end;
    logic [7:0] data;
  } word_t;

  typedef struct {
    logic [63:0] value;
    logic        status;
  } decoded_t;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = 4;

  // {buffer end, byte}
  localparam logic [8:0] DIRECTED [23] = '{
    9'h000, 9'h17F,
    9'h080, 9'h100,
    9'h0BF, 9'h0FF,
    9'h0F0, 9'h012, 9'h034, 9'h056, 9'h078,
    9'h0FF, 9'h080, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h001,
    9'h1C0,
    9'h0E0, 9'h155
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_buffer_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] out_decoded_value;
  logic               out_status;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;

  word_t       pending_words[$];
  decoded_t    expected_values[$];
  int unsigned words_queued = 0;
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold = 1'b0;
  logic        rx_hold_req = 1'b0;
  logic        in_taken = 1'b0;

  // decoder state as seen by the predictor
  logic        long_mode_q;
  logic [3:0]  seen_q;
  logic [3:0]  total_q;
  logic [7:0]  lead_q;
  logic [63:0] acc_q;

  compact_varint_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_buffer_end     (in_buffer_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_decoded_value (out_decoded_value),
    .out_status        (out_status),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [3:0] lead_length(input logic [7:0] lead);
    logic [3:0] len;
    len = 4'd1;
    for (int i = 7; i >= 0; i--) begin
      if (!lead[i]) break;
      len++;
    end
    return len;
  endfunction

  function automatic logic [63:0] assemble(input logic [7:0] lead, input int len,
                                           input logic [63:0] acc, input logic long_m);
    logic [63:0] raw;
    int          bits;
    if (len >= 5 && !long_m) return {{32{acc[31]}}, acc[31:0]};
    if (len >= 9) return acc;
    bits = 7 * len;
    raw = ((64'(lead) & ((64'd1 << (8 - len)) - 64'd1)) << (8 * (len - 1))) | acc;
    return 64'($signed(raw << (64 - bits)) >>> (64 - bits));
  endfunction

  task automatic decode_word(input word_t w);
    logic [3:0]  len;
    logic [63:0] v;
    logic        done;
    logic        under;
    done = 1'b0;
    under = 1'b0;
    v = '0;
    if (seen_q == 4'd0) begin
      len = lead_length(w.data);
      if (len == 4'd1) begin
        done = 1'b1;
        v = assemble(w.data, 1, 64'd0, long_mode_q);
      end else if (w.buf_end) begin
        under = 1'b1;
      end else begin
        lead_q = w.data;
        total_q = len;
        seen_q = 4'd1;
        acc_q = '0;
      end
    end else begin
      acc_q = {acc_q[55:0], w.data};
      seen_q++;
      if (seen_q >= total_q) begin
        done = 1'b1;
        v = assemble(lead_q, int'(total_q), acc_q, long_mode_q);
        seen_q = 4'd0;
      end else if (w.buf_end) begin
        under = 1'b1;
        seen_q = 4'd0;
      end
    end
    if (done) expected_values.push_back('{value: v, status: cvd_pkg::STATUS_OK});
    else if (under)
      expected_values.push_back('{value: 64'd0, status: cvd_pkg::STATUS_UNDERFLOW});
  endtask

  always @(posedge clk) begin
    decoded_t exp_r;
    if (!rst_n) begin
      long_mode_q = 1'b1;
      seen_q = '0;
      total_q = '0;
      lead_q = '0;
      acc_q = '0;
      in_taken = 1'b0;
    end else begin
      if (cfg_wr_en) long_mode_q = cfg_wr_data;
      in_taken = in_valid && in_ready;
      if (in_taken) decode_word(word_t'({in_buffer_end, in_data_byte}));
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %h status %b", out_decoded_value, out_status);
        end else begin
          exp_r = expected_values.pop_front();
          if (out_decoded_value !== exp_r.value || out_status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h status %b, got value %h status %b",
                       exp_r.value, exp_r.status, out_decoded_value, out_status);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= w.data;
        in_buffer_end <= w.buf_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // hold off the receiver on request
  initial begin
    forever begin
      wait (rx_hold_req);
      @(posedge clk);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
      wait (!rx_hold_req);
    end
  end

  task automatic push_word(input word_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_value(input int len, input bit cut);
    logic [7:0] lead;
    int         stop;
    word_t      w;
    lead = 8'($urandom);
    if (len == 9) begin
      lead = 8'hFF;
    end else begin
      for (int i = 0; i < len - 1; i++) lead[7 - i] = 1'b1;
      lead[8 - len] = 1'b0;
    end
    stop = cut ? $urandom_range(len - 2) : len - 1;
    for (int i = 0; i <= stop; i++) begin
      if (i == 0) w.data = lead;
      else if ($urandom_range(3) == 0) w.data = $urandom_range(1) ? 8'hFF : 8'h00;
      else w.data = 8'($urandom);
      if (i != stop) w.buf_end = 1'b0;
      else w.buf_end = cut ? 1'b1 : ($urandom_range(3) == 0);
      push_word(w);
    end
  endtask

  task automatic fill_random(input int unsigned n);
    int unsigned target;
    int unsigned pick;
    word_t       w;
    target = words_queued + n;
    while (words_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        queue_value($urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(5, 9), 1'b0);
      end else if (pick < 90) begin
        queue_value($urandom_range(2, 9), 1'b1);
      end else begin
        w.data = 8'($urandom);
        w.buf_end = ($urandom_range(3) == 0);
        push_word(w);
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() != 0 || in_valid || expected_values.size() != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;

    foreach (DIRECTED[i]) push_word(word_t'(DIRECTED[i]));
    settle();

    for (int p = 0; p < 8; p++) begin
      write_mode(p[0]);
      case (p >> 1)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      fill_random(85);
      wait_drained();
      fill_random(85);
      settle();
    end

    write_mode(1'b1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_req = 1'b1;
    fill_random(120);
    wait_drained();
    rx_hold_req = 1'b0;

    write_mode(1'b0);
    fill_random(60);
    settle();
    repeat (10) @(posedge clk);
    #1;

    mismatches += expected_values.size();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: compact_varint_decoder.f
hdl/cvd_pkg.sv
hdl/cvd_decode.sv
hdl/compact_varint_decoder.sv
tb/tb.sv
